// File: hw/rtl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the shortest-seek-time-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int TRACK_W            = 8;
    localparam int WINDOW_DEPTH_DEF   = 8;

    // Request function codes
    localparam logic FUNC_NEW   = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef logic [TRACK_W-1:0] track_t;

    typedef struct packed {
        logic   func;
        track_t request_track;
    } sstf_req_t;

    typedef struct packed {
        track_t served_track;
        track_t seek_distance;
        logic   nothing_pending;
    } sstf_rsp_t;

endpackage

// File: hw/rtl/sstf_disk_request_scheduler_unit.sv
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_unit
// Shortest-seek-time-first scheduler over a window of pending track requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (valid/ready). A new request taken while
//   a slot is free is stored in the lowest free slot in the accepting cycle and
//   gives no result; s_ready stays high.
//   A new request into a full window, or a drain transaction, starts a scan of
//   the track RAM: one slot read per cycle, then one result transaction on the
//   m_ channel. The scan length is set by the single read port of the track
//   RAM. Ties go to the lowest slot.
//   A drain of an empty window returns nothing_pending with zero fields.
//   start_track is written through cfg_wr_en/cfg_wr_data and is latched into
//   the head position by the first transaction after reset.
//   Reset (aresetn, synchronous, active low) clears all valid bits, the head
//   and the output valid bit; the RAM and the result data hold no reset value.
//   If the receiver stalls, the block waits in its serve step until the
//   previous result has been taken; no result is dropped.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_unit
    import sstf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    // configuration
    input  logic      cfg_wr_en,
    input  track_t    cfg_wr_data,
    // request channel
    input  logic      s_valid,
    output logic      s_ready,
    input  sstf_req_t s_data,
    // result channel
    output logic      m_valid,
    input  logic      m_ready,
    output sstf_rsp_t m_data
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SERVE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    track_t                  start_track_reg;
    track_t                  head_reg;
    logic                    head_loaded_reg;
    logic [WINDOW_DEPTH-1:0] slot_valid_reg;
    sstf_req_t               req_reg;
    logic [CNT_W-1:0]        scan_cnt_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    best_found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    track_t                  best_track_reg;
    track_t                  best_gap_reg;
    logic                    m_valid_reg;
    sstf_rsp_t               m_data_reg;

    logic                    s_fire;
    logic                    serve_fire;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    track_t                  head_now;
    track_t                  rd_track;
    track_t                  gap;
    logic                    take_best;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    track_t                  wr_data;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign serve_fire = (state_reg == ST_SERVE) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign head_now = head_loaded_reg ? head_reg : start_track_reg;

    // Scan compare on registered RAM data
    assign gap       = (rd_track > head_reg) ? (rd_track - head_reg) : (head_reg - rd_track);
    assign take_best = cmp_vld_reg && slot_valid_reg[cmp_idx_reg]
                       && (!best_found_reg || (gap < best_gap_reg));

    // RAM write: free-slot fill on accept, or refill of the served slot
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = free_idx;
        wr_data = s_data.request_track;
        if (serve_fire) begin
            wr_en   = (req_reg.func == FUNC_NEW) && best_found_reg;
            wr_addr = best_idx_reg;
            wr_data = req_reg.request_track;
        end else if (s_fire) begin
            wr_en   = (s_data.func == FUNC_NEW) && free_found;
        end
    end

    sstf_track_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (IDX_W)
    ) u_track_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_track)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && !((s_data.func == FUNC_NEW) && free_found)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg == CNT_LAST) begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE: begin
                if (serve_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            start_track_reg <= '0;
            head_reg        <= '0;
            head_loaded_reg <= 1'b0;
            slot_valid_reg  <= '0;
            scan_cnt_reg    <= '0;
            cmp_vld_reg     <= 1'b0;
            best_found_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                start_track_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                head_reg        <= head_now;
                head_loaded_reg <= 1'b1;
                scan_cnt_reg    <= '0;
                best_found_reg  <= 1'b0;
                if ((s_data.func == FUNC_NEW) && free_found) begin
                    slot_valid_reg[free_idx] <= 1'b1;
                end
            end
            if (state_reg == ST_SCAN) begin
                cmp_vld_reg <= (scan_cnt_reg != CNT_LAST);
                if (scan_cnt_reg != CNT_LAST) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end else begin
                cmp_vld_reg <= 1'b0;
            end
            if (take_best) begin
                best_found_reg <= 1'b1;
            end
            if (serve_fire) begin
                m_valid_reg <= 1'b1;
                if (best_found_reg) begin
                    head_reg <= best_track_reg;
                    // a drain frees the slot; a new request keeps it occupied
                    if (req_reg.func == FUNC_DRAIN) begin
                        slot_valid_reg[best_idx_reg] <= 1'b0;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_SCAN) begin
            cmp_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        end
        if (take_best) begin
            best_idx_reg   <= cmp_idx_reg;
            best_track_reg <= rd_track;
            best_gap_reg   <= gap;
        end
        if (serve_fire) begin
            if (best_found_reg) begin
                m_data_reg.served_track    <= best_track_reg;
                m_data_reg.seek_distance   <= best_gap_reg;
                m_data_reg.nothing_pending <= 1'b0;
            end else begin
                m_data_reg.served_track    <= '0;
                m_data_reg.seek_distance   <= '0;
                m_data_reg.nothing_pending <= 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/sstf_track_ram.sv
// ----------------------------------------------------------------------------
// sstf_track_ram
// Pending-track store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sstf_track_ram
    import sstf_pkg::*;
#(
    parameter int DEPTH  = WINDOW_DEPTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  track_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output track_t            rd_data
);

    track_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: tb/sstf_disk_request_scheduler_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_unit_test
// Self-checking bench for the shortest-seek-time-first scheduler. A class
// tracks the pending window and the head, predicts every served track,
// seek distance and empty-drain flag, and compares them with the results.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_unit_test;
    import sstf_pkg::*;

    localparam int DEPTH      = WINDOW_DEPTH_DEF;
    localparam int CYCLE_CAP  = 300000;   // far beyond the slowest legal run
    localparam int HOLD_AT    = 150;      // result count that starts the long stall
    localparam int HOLD_LEN   = 400;      // cycles of m_ready low during that stall
    localparam int SETTLE     = 20;       // covers a full scan after the last result
    localparam int RAND_ITEMS = 1150;

    // ------------------------------------------------------------------------
    // Seek model: own copy of the window, the head and start_track. Each
    // accepted request transaction yields zero or one expected service.
    // ------------------------------------------------------------------------
    class seek_board;
        track_t    slot_track [DEPTH];
        bit        slot_busy  [DEPTH];
        track_t    head;
        bit        head_set;
        track_t    start_pos;
        sstf_rsp_t due_services[$];
        int        mismatches;

        function new();
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            head       = '0;
            head_set   = 1'b0;
            start_pos  = '0;
            mismatches = 0;
        endfunction

        function void set_start(track_t v);
            start_pos = v;
        endfunction

        function track_t gap_to_head(track_t t);
            return (t > head) ? track_t'(t - head) : track_t'(head - t);
        endfunction

        function int busy_count();
            int n;
            n = 0;
            foreach (slot_busy[i]) if (slot_busy[i]) n++;
            return n;
        endfunction

        // lowest busy slot at the smallest distance, -1 when empty
        function int nearest_slot();
            int     best;
            track_t best_gap;
            best     = -1;
            best_gap = '0;
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_busy[i] && (best < 0 || gap_to_head(slot_track[i]) < best_gap)) begin
                    best     = i;
                    best_gap = gap_to_head(slot_track[i]);
                end
            end
            return best;
        endfunction

        function void serve(int s);
            sstf_rsp_t r;
            r.served_track    = slot_track[s];
            r.seek_distance   = gap_to_head(slot_track[s]);
            r.nothing_pending = 1'b0;
            due_services.push_back(r);
            head = slot_track[s];
        endfunction

        function void note_request(sstf_req_t q);
            int s;
            // first transaction after reset loads the head; later writes are dead
            if (!head_set) begin
                head     = start_pos;
                head_set = 1'b1;
            end
            if (q.func == FUNC_NEW) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!slot_busy[i]) begin
                        slot_track[i] = q.request_track;
                        slot_busy[i]  = 1'b1;
                        return;
                    end
                end
                s = nearest_slot();
                serve(s);
                slot_track[s] = q.request_track;
            end else begin
                s = nearest_slot();
                if (s < 0) begin
                    due_services.push_back('{served_track: '0, seek_distance: '0,
                                             nothing_pending: 1'b1});
                end else begin
                    serve(s);
                    slot_busy[s] = 1'b0;
                end
            end
        endfunction

        function void check_service(sstf_rsp_t got);
            sstf_rsp_t want;
            if (due_services.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: track %0d dist %0d empty %0b",
                             got.served_track, got.seek_distance, got.nothing_pending);
                return;
            end
            want = due_services.pop_front();
            if (got.served_track    !== want.served_track  ||
                got.seek_distance   !== want.seek_distance ||
                got.nothing_pending !== want.nothing_pending) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp %0d/%0d/%0b, got %0d/%0d/%0b",
                             want.served_track, want.seek_distance, want.nothing_pending,
                             got.served_track, got.seek_distance, got.nothing_pending);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hook-up; every input starts at a known value
    // ------------------------------------------------------------------------
    logic      aclk;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    track_t    cfg_wr_data = '0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    sstf_req_t s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    sstf_rsp_t m_data;

    sstf_disk_request_scheduler_unit #(
        .WINDOW_DEPTH (DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    seek_board board;
    bit        gaps_on = 1'b1;   // cleared for stretches with no idling on either side
    int        results_seen = 0;
    int        reqs_sent = 0;
    int        cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("sstf_disk_request_scheduler_unit_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Values are sampled at the edge, before the DUT's updates
    // land. After each transaction a fresh random wait is drawn while gaps are
    // on; once, at HOLD_AT results, m_ready is held low until HOLD_LEN runs out, so the
    // window fills and s_ready drops while the sender keeps offering.
    // ------------------------------------------------------------------------
    int rsp_wait   = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                board.check_service(m_data);
                results_seen++;
                rsp_wait = gaps_on ? $urandom_range(0, 3) : 0;
                if (results_seen == HOLD_AT)
                    stall_left = HOLD_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rsp_wait > 0) begin
                rsp_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // One request transaction: optional idle gap, then hold valid until taken.
    // Returns at the accepting edge with s_valid still high.
    task automatic send_req(input logic f, input track_t t);
        sstf_req_t q;
        int        gap;
        q.func          = f;
        q.request_track = t;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= q;
        do @(posedge aclk); while (!s_ready);
        board.note_request(q);
        reqs_sent++;
    endtask

    // start_track write; two back-to-back calls never stack edges on cfg_wr_en
    task automatic write_start(input track_t v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_start(v);
    endtask

    // Drop valid, let every expected result out, then allow a trailing scan.
    task automatic drain_out();
        s_valid <= 1'b0;
        while (board.due_services.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly in-range tracks, some above 199, some hard against the head.
    function automatic track_t pick_track();
        int r;
        int h;
        r = $urandom_range(0, 99);
        h = board.head;
        if (r < 60) return track_t'($urandom_range(0, 199));
        if (r < 72) return track_t'($urandom_range(200, 255));
        if (r < 80) return (r[0]) ? 8'd0 : 8'd255;
        h = h + $urandom_range(0, 6) - 3;
        if (h < 0)   h = 0;
        if (h > 255) h = 255;
        return track_t'(h);
    endfunction

    // Random phase: bursts of mixed traffic, full drains and equal-distance pairs.
    task automatic random_phase(input int count);
        int kind;
        int len;
        int h;
        int d;
        int goal;
        goal = reqs_sent + count;
        while (reqs_sent < goal) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 99);
            if (kind < 70) begin
                len = $urandom_range(8, 40);
                repeat (len)
                    if ($urandom_range(0, 99) < 72)
                        send_req(FUNC_NEW, pick_track());
                    else
                        send_req(FUNC_DRAIN, track_t'($urandom_range(0, 255)));
            end else if (kind < 85) begin
                // empty the window and knock once or twice more on the empty side
                len = board.busy_count() + $urandom_range(1, 2);
                repeat (len) send_req(FUNC_DRAIN, track_t'($urandom_range(0, 255)));
            end else begin
                // two tracks at the same distance either side of the head
                h = board.head;
                d = $urandom_range(1, 20);
                if (h - d >= 0 && h + d <= 255) begin
                    send_req(FUNC_NEW, track_t'(h + d));
                    send_req(FUNC_NEW, track_t'(h - d));
                end
                repeat ($urandom_range(1, 4)) send_req(FUNC_NEW, pick_track());
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        track_t fill [8];
        int     h;
        board = new();
        fill  = '{8'd0, 8'd255, 8'd199, 8'd100, 8'd50, 8'd150, 8'd200, 8'd1};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // only the last write before the first transaction reaches the head
        write_start(8'd0);
        write_start(8'd199);

        // drain on an empty window; this also latches the head
        send_req(FUNC_DRAIN, 8'hFF);
        // fill every slot, range extremes and out-of-range tracks included
        foreach (fill[i]) send_req(FUNC_NEW, fill[i]);
        // full window: each new request forces a service first
        send_req(FUNC_NEW, 8'd120);
        send_req(FUNC_NEW, 8'd180);
        send_req(FUNC_NEW, 8'd210);
        send_req(FUNC_NEW, 8'd90);
        // serve everything, then one drain too many
        repeat (DEPTH + 1) send_req(FUNC_DRAIN, 8'h00);
        // equal distance either side: lower slot must win
        h = board.head;
        send_req(FUNC_NEW, track_t'((h <= 250) ? h + 5 : h - 10));
        send_req(FUNC_NEW, track_t'((h >= 5) ? h - 5 : h + 10));
        send_req(FUNC_DRAIN, 8'h00);
        send_req(FUNC_DRAIN, 8'h00);
        drain_out();

        // late writes must not move the head
        write_start(8'd255);
        random_phase(RAND_ITEMS / 3);
        drain_out();
        write_start(8'd0);
        random_phase(RAND_ITEMS / 3);
        drain_out();
        write_start(track_t'($urandom_range(0, 255)));
        random_phase(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
        drain_out();

        if (board.mismatches == 0 && board.due_services.size() == 0)
            $display("sstf_disk_request_scheduler_unit_test: PASS");
        else
            $display("sstf_disk_request_scheduler_unit_test: FAIL");
        $finish;
    end

endmodule
